// ===== hw/rtl/vrsm_pkg.sv =====
// Shared types, register indexes and reset values for the vertex rotate, scale and move block.
package vrsm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COS_ANGLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIN_ANGLE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET       = 3'd5;

    localparam logic [1:0] MODE_ROTATE = 2'd0;
    localparam logic [1:0] MODE_SCALE  = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0]         RST_MODE         = MODE_SCALE;
    localparam logic [1:0]         RST_AXIS         = AXIS_X;
    localparam logic signed [17:0] RST_COS_ANGLE    = 18'sd65536;
    localparam logic signed [17:0] RST_SIN_ANGLE    = 18'sd0;
    localparam logic signed [31:0] RST_SCALE_FACTOR = 32'sd65536;
    localparam logic signed [31:0] RST_OFFSET       = 32'sd0;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_in;
    } vertex_in_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               last_out;
    } vertex_out_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         axis;
        logic signed [17:0] cos_angle;
        logic signed [17:0] sin_angle;
        logic signed [31:0] scale_factor;
        logic signed [31:0] offset;
    } cfg_t;

endpackage

// ===== hw/rtl/vertex_rotate_scale_move.sv =====
// Four-stage pipeline that rotates, scales or moves one fixed-point vertex per item.
// An accepted item goes through the input, operand, product and result registers in order.
// Throughput is one item per cycle; all four products are formed side by side in one stage.
// A result-side stall holds full stages at the output; s_ready drops once all are full.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
module vertex_rotate_scale_move (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  vrsm_pkg::vertex_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output vrsm_pkg::vertex_out_t               m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vrsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vrsm_pkg::*;

    localparam logic [1:0] OP_PASS  = 2'd0;
    localparam logic [1:0] OP_ROT   = 2'd1;
    localparam logic [1:0] OP_SCALE = 2'd2;

    function automatic logic [31:0] sat_shift(input logic [64:0] v);
        logic [48:0] sh;
        sh = v[64:16];
        if ((&sh[48:31]) || !(|sh[48:31])) begin
            return sh[31:0];
        end
        return sh[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] == s[31]) begin
            return s[31:0];
        end
        return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    cfg_t cfg;

    vrsm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    vertex_in_t in1_reg;

    logic [1:0]         op2_reg, op2_next;
    logic [1:0]         axis2_reg;
    logic [31:0]        x2_reg, y2_reg, z2_reg;
    logic [31:0]        x2_next, y2_next, z2_next;
    logic               last2_reg;
    logic signed [31:0] opa2_reg [4];
    logic signed [31:0] opb2_reg [4];
    logic signed [31:0] opa2_next [4];
    logic signed [31:0] opb2_next [4];

    logic [1:0]         op3_reg;
    logic [1:0]         axis3_reg;
    logic [31:0]        x3_reg, y3_reg, z3_reg;
    logic               last3_reg;
    logic signed [63:0] prod3_reg [4];
    logic signed [63:0] prod3_next [4];

    vertex_out_t out4_reg, out4_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            in1_reg <= s_data;
        end
    end

    always_comb begin
        logic signed [31:0] c_ext;
        logic signed [31:0] s_ext;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        c_ext    = {{14{cfg.cos_angle[17]}}, cfg.cos_angle};
        s_ext    = {{14{cfg.sin_angle[17]}}, cfg.sin_angle};
        op2_next = OP_PASS;
        x2_next  = in1_reg.pos_x;
        y2_next  = in1_reg.pos_y;
        z2_next  = in1_reg.pos_z;
        pa       = in1_reg.pos_x;
        pb       = in1_reg.pos_y;
        for (int k = 0; k < 4; k++) begin
            opa2_next[k] = '0;
            opb2_next[k] = '0;
        end
        case (cfg.axis)
            AXIS_X: begin
                pa = in1_reg.pos_y;
                pb = in1_reg.pos_z;
            end
            AXIS_Y: begin
                pa = in1_reg.pos_x;
                pb = in1_reg.pos_z;
            end
            default: begin
                pa = in1_reg.pos_x;
                pb = in1_reg.pos_y;
            end
        endcase
        case (cfg.mode)
            MODE_ROTATE: begin
                if (cfg.axis inside {AXIS_X, AXIS_Y, AXIS_Z}) begin
                    op2_next     = OP_ROT;
                    opa2_next[0] = c_ext;
                    opb2_next[0] = pa;
                    opa2_next[1] = s_ext;
                    opb2_next[1] = pb;
                    opa2_next[2] = s_ext;
                    opb2_next[2] = pa;
                    opa2_next[3] = c_ext;
                    opb2_next[3] = pb;
                end
            end
            MODE_SCALE: begin
                if (cfg.scale_factor != '0) begin
                    op2_next     = OP_SCALE;
                    opa2_next[0] = cfg.scale_factor;
                    opb2_next[0] = in1_reg.pos_x;
                    opa2_next[1] = cfg.scale_factor;
                    opb2_next[1] = in1_reg.pos_y;
                    opa2_next[2] = cfg.scale_factor;
                    opb2_next[2] = in1_reg.pos_z;
                end
            end
            MODE_MOVE: begin
                case (cfg.axis)
                    AXIS_X:  x2_next = add_sat(in1_reg.pos_x, cfg.offset);
                    AXIS_Y:  y2_next = add_sat(in1_reg.pos_y, cfg.offset);
                    AXIS_Z:  z2_next = add_sat(in1_reg.pos_z, cfg.offset);
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            op2_reg   <= op2_next;
            axis2_reg <= cfg.axis;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            z2_reg    <= z2_next;
            last2_reg <= in1_reg.last_in;
            for (int k = 0; k < 4; k++) begin
                opa2_reg[k] <= opa2_next[k];
                opb2_reg[k] <= opb2_next[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod3_next[k] = opa2_reg[k] * opb2_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            op3_reg   <= op2_reg;
            axis3_reg <= axis2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            last3_reg <= last2_reg;
            for (int k = 0; k < 4; k++) begin
                prod3_reg[k] <= prod3_next[k];
            end
        end
    end

    always_comb begin
        logic [64:0] sum_a;
        logic [64:0] sum_b;
        logic [31:0] rot_a;
        logic [31:0] rot_b;
        sum_a = {prod3_reg[0][63], prod3_reg[0]} - {prod3_reg[1][63], prod3_reg[1]};
        sum_b = {prod3_reg[2][63], prod3_reg[2]} + {prod3_reg[3][63], prod3_reg[3]};
        rot_a = sat_shift(sum_a);
        rot_b = sat_shift(sum_b);
        out4_next.new_x    = x3_reg;
        out4_next.new_y    = y3_reg;
        out4_next.new_z    = z3_reg;
        out4_next.last_out = last3_reg;
        case (op3_reg)
            OP_ROT: begin
                case (axis3_reg)
                    AXIS_X: begin
                        out4_next.new_y = rot_a;
                        out4_next.new_z = rot_b;
                    end
                    AXIS_Y: begin
                        out4_next.new_x = rot_a;
                        out4_next.new_z = rot_b;
                    end
                    default: begin
                        out4_next.new_x = rot_a;
                        out4_next.new_y = rot_b;
                    end
                endcase
            end
            OP_SCALE: begin
                out4_next.new_x = sat_shift({prod3_reg[0][63], prod3_reg[0]});
                out4_next.new_y = sat_shift({prod3_reg[1][63], prod3_reg[1]});
                out4_next.new_z = sat_shift({prod3_reg[2][63], prod3_reg[2]});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            out4_reg <= out4_next;
        end
    end

    assign m_data = out4_reg;

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input blocked while the pipeline has an empty stage");

    a_products_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(prod3_reg[0]) && $stable(prod3_reg[2])))
        else $error("product stage changed during a stall");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && m_ready && !v3_reg) |=> !v4_reg)
        else $error("result item repeated after it was taken");

endmodule

// ===== hw/rtl/vrsm_cfg.sv =====
// Configuration register bank for the vertex rotate, scale and move block.
module vrsm_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vrsm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vrsm_pkg::cfg_t                      cfg
);
    import vrsm_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= RST_MODE;
            cfg_reg.axis         <= RST_AXIS;
            cfg_reg.cos_angle    <= RST_COS_ANGLE;
            cfg_reg.sin_angle    <= RST_SIN_ANGLE;
            cfg_reg.scale_factor <= RST_SCALE_FACTOR;
            cfg_reg.offset       <= RST_OFFSET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:         cfg_reg.mode         <= cfg_data[1:0];
                REG_AXIS:         cfg_reg.axis         <= cfg_data[1:0];
                REG_COS_ANGLE:    cfg_reg.cos_angle    <= cfg_data[17:0];
                REG_SIN_ANGLE:    cfg_reg.sin_angle    <= cfg_data[17:0];
                REG_SCALE_FACTOR: cfg_reg.scale_factor <= cfg_data;
                REG_OFFSET:       cfg_reg.offset       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== bench/tb_vertex_rotate_scale_move.sv =====
// Self-checking testbench for the vertex rotate, scale and move pipeline.
`timescale 1ns / 1ps

module tb_vertex_rotate_scale_move;
    import vrsm_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int  IDLE_GUARD = 6;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    vertex_in_t             s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    vertex_out_t            m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cfg_t        shadow_cfg;
    vertex_out_t pending_vertices[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;
    logic        receiver_hold = 1'b0;

    vertex_rotate_scale_move DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint q16_clamp(input longint v);
        return clamp32(v >>> 16);
    endfunction

    function automatic vertex_out_t transform_vertex(input vertex_in_t v, input cfg_t c);
        longint      p[3];
        longint      cs;
        longint      sn;
        longint      a;
        longint      b;
        int          ia;
        int          ib;
        vertex_out_t r;
        p[0] = longint'($signed(v.pos_x));
        p[1] = longint'($signed(v.pos_y));
        p[2] = longint'($signed(v.pos_z));
        cs = longint'($signed(c.cos_angle));
        sn = longint'($signed(c.sin_angle));
        ia = -1;
        ib = -1;
        case (c.mode)
            MODE_ROTATE: begin
                case (c.axis)
                    AXIS_X: begin ia = 1; ib = 2; end
                    AXIS_Y: begin ia = 0; ib = 2; end
                    AXIS_Z: begin ia = 0; ib = 1; end
                    default: ;
                endcase
                if (ia >= 0) begin
                    a = p[ia];
                    b = p[ib];
                    p[ia] = q16_clamp(cs * a - sn * b);
                    p[ib] = q16_clamp(sn * a + cs * b);
                end
            end
            MODE_SCALE: begin
                if (c.scale_factor != 0) begin
                    for (int k = 0; k < 3; k++) begin
                        p[k] = q16_clamp(p[k] * longint'($signed(c.scale_factor)));
                    end
                end
            end
            MODE_MOVE: begin
                if (c.axis != AXIS_NONE) begin
                    p[c.axis] = clamp32(p[c.axis] + longint'($signed(c.offset)));
                end
            end
            default: ;
        endcase
        r.new_x = p[0][31:0];
        r.new_y = p[1][31:0];
        r.new_z = p[2][31:0];
        r.last_out = v.last_in;
        return r;
    endfunction

    function automatic vertex_in_t make_vertex(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z, input logic last);
        vertex_in_t v;
        v.pos_x = x;
        v.pos_y = y;
        v.pos_z = z;
        v.last_in = last;
        return v;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return W_MAX;
            1: return W_MIN;
            2, 3, 4: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint exp, input longint act);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, exp, act);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            receiver_hold <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            receiver_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        m_ready <= receiver_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        vertex_out_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (pending_vertices.size() == 0) begin
                report_mismatch("unexpected item, x", 64'sd0,
                                longint'($signed(m_data.new_x)));
            end else begin
                exp_v = pending_vertices.pop_front();
                if (m_data.new_x !== exp_v.new_x)
                    report_mismatch("new_x", longint'($signed(exp_v.new_x)),
                                    longint'($signed(m_data.new_x)));
                if (m_data.new_y !== exp_v.new_y)
                    report_mismatch("new_y", longint'($signed(exp_v.new_y)),
                                    longint'($signed(m_data.new_y)));
                if (m_data.new_z !== exp_v.new_z)
                    report_mismatch("new_z", longint'($signed(exp_v.new_z)),
                                    longint'($signed(m_data.new_z)));
                if (m_data.last_out !== exp_v.last_out)
                    report_mismatch("last_out", longint'(exp_v.last_out),
                                    longint'(m_data.last_out));
            end
        end
    end

    task automatic send_vertex(input vertex_in_t v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_vertices.push_back(transform_vertex(v, shadow_cfg));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:         shadow_cfg.mode = data[1:0];
            REG_AXIS:         shadow_cfg.axis = data[1:0];
            REG_COS_ANGLE:    shadow_cfg.cos_angle = data[17:0];
            REG_SIN_ANGLE:    shadow_cfg.sin_angle = data[17:0];
            REG_SCALE_FACTOR: shadow_cfg.scale_factor = data;
            REG_OFFSET:       shadow_cfg.offset = data;
            default: ;
        endcase
    endtask

    task automatic write_field(input logic [CFG_INDEX_W-1:0] idx, input logic [17:0] value,
                               input int width);
        logic [31:0] data;
        data = $urandom();
        for (int k = 0; k < width; k++) data[k] = value[k];
        write_reg(idx, data);
    endtask

    task automatic random_config();
        int pick;
        logic [17:0] trig;
        pick = $urandom_range(9);
        write_field(REG_MODE, 18'((pick < 3) ? MODE_ROTATE : (pick < 6) ? MODE_SCALE :
                                  (pick < 9) ? MODE_MOVE : MODE_NONE), 2);
        write_field(REG_AXIS, ($urandom_range(7) == 0) ? 18'(AXIS_NONE) :
                              18'($urandom_range(2)), 2);
        trig = ($urandom_range(5) == 0) ? 18'($urandom()) : 18'($urandom_range(131072) - 65536);
        write_field(REG_COS_ANGLE, trig, 18);
        trig = ($urandom_range(5) == 0) ? 18'($urandom()) : 18'($urandom_range(131072) - 65536);
        write_field(REG_SIN_ANGLE, trig, 18);
        case ($urandom_range(5))
            0: write_reg(REG_SCALE_FACTOR, 32'd0);
            1, 2: write_reg(REG_SCALE_FACTOR, $urandom());
            default: write_reg(REG_SCALE_FACTOR, $urandom_range(32'h0008_0000) - 32'h0004_0000);
        endcase
        write_reg(REG_OFFSET, $urandom_range(1) ? $urandom() : rand_coord());
        if ($urandom_range(7) == 0) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                              $urandom());
    endtask

    task automatic test_reset_values();
        send_vertex(make_vertex(W_MAX, W_MIN, 32'h0001_8000, 1'b1));
        send_vertex(make_vertex($urandom(), 32'hffff_ffff, 32'd0, 1'b0));
    endtask

    task automatic test_rotate();
        write_field(REG_MODE, 18'(MODE_ROTATE), 2);
        write_field(REG_COS_ANGLE, 18'd0, 18);
        write_field(REG_SIN_ANGLE, 18'd65536, 18);
        for (int a = 0; a < 3; a++) begin
            write_field(REG_AXIS, 18'(a), 2);
            send_vertex(make_vertex(ONE_Q16, 32'h0002_0000, 32'hfffd_0000, a[0]));
        end
        write_field(REG_COS_ANGLE, 18'h1ffff, 18);
        write_field(REG_SIN_ANGLE, 18'h20000, 18);
        for (int a = 0; a < 3; a++) begin
            write_field(REG_AXIS, 18'(a), 2);
            send_vertex(make_vertex(W_MAX, W_MIN, W_MAX, 1'b1));
        end
        write_field(REG_AXIS, 18'(AXIS_NONE), 2);
        send_vertex(make_vertex($urandom(), $urandom(), $urandom(), 1'b0));
    endtask

    task automatic test_scale();
        write_field(REG_MODE, 18'(MODE_SCALE), 2);
        write_reg(REG_SCALE_FACTOR, 32'd0);
        send_vertex(make_vertex(W_MAX, W_MIN, 32'hffff_ffff, 1'b1));
        write_reg(REG_SCALE_FACTOR, W_MAX);
        send_vertex(make_vertex(W_MAX, W_MIN, 32'hffff_ffff, 1'b0));
        write_reg(REG_SCALE_FACTOR, W_MIN);
        send_vertex(make_vertex(W_MIN, W_MAX, 32'h0000_0001, 1'b1));
        write_reg(REG_SCALE_FACTOR, 32'hffff_0000);
        send_vertex(make_vertex(W_MIN, W_MAX, 32'h0003_4000, 1'b0));
        write_field(REG_MODE, 18'(MODE_NONE), 2);
        send_vertex(make_vertex($urandom(), $urandom(), $urandom(), 1'b1));
    endtask

    task automatic test_move();
        write_field(REG_MODE, 18'(MODE_MOVE), 2);
        write_field(REG_AXIS, 18'(AXIS_X), 2);
        write_reg(REG_OFFSET, W_MAX);
        send_vertex(make_vertex(W_MAX, W_MIN, 32'd5, 1'b0));
        write_field(REG_AXIS, 18'(AXIS_Y), 2);
        write_reg(REG_OFFSET, W_MIN);
        send_vertex(make_vertex(W_MAX, W_MIN, 32'd5, 1'b1));
        write_field(REG_AXIS, 18'(AXIS_Z), 2);
        write_reg(REG_OFFSET, ONE_Q16);
        send_vertex(make_vertex($urandom(), $urandom(), 32'hfff0_0000, 1'b0));
        write_field(REG_AXIS, 18'(AXIS_NONE), 2);
        send_vertex(make_vertex(W_MIN, W_MAX, 32'd0, 1'b1));
    endtask

    task automatic test_spare_index();
        write_field(REG_MODE, 18'(MODE_SCALE), 2);
        write_reg(REG_SCALE_FACTOR, 32'h0002_0000);
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        send_vertex(make_vertex(32'h0000_8000, 32'hffff_8000, 32'h4000_0000, 1'b1));
    endtask

    task automatic test_random(input int items, input int send_pct, input int recv_pct);
        int until_reconfig;
        until_reconfig = 0;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < items; i++) begin
            if (until_reconfig == 0) begin
                random_config();
                until_reconfig = $urandom_range(60, 20);
            end
            until_reconfig--;
            send_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                    1'($urandom_range(1))));
        end
    endtask

    task automatic test_backpressure();
        random_config();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left <= 300;
        for (int i = 0; i < 48; i++) begin
            send_vertex(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                    1'($urandom_range(1))));
        end
    endtask

    initial begin
        shadow_cfg.mode = RST_MODE;
        shadow_cfg.axis = RST_AXIS;
        shadow_cfg.cos_angle = RST_COS_ANGLE;
        shadow_cfg.sin_angle = RST_SIN_ANGLE;
        shadow_cfg.scale_factor = RST_SCALE_FACTOR;
        shadow_cfg.offset = RST_OFFSET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_rotate();
        test_scale();
        test_move();
        test_spare_index();
        test_random(270, 0, 0);
        test_random(270, 86, 0);
        test_random(270, 0, 86);
        test_random(270, 21, 21);
        test_backpressure();

        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
